// ----- sv/lmts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmts_pkg
// Shared types and constants of the LED matrix text scroller.
// ----------------------------------------------------------------------------
package lmts_pkg;

	localparam int ROWS_DEF    = 8;
	localparam int COLUMNS_DEF = 8;
	localparam int MSG_MAX_DEF = 64;

	localparam int FONT_DEPTH  = 768;
	localparam int GLYPHS      = 96;
	localparam logic [6:0] FIRST_CODE = 7'd32;
	localparam logic [7:0] RED_RESET  = 8'h01;
	localparam logic [6:0] MSG_LEN_RESET = 7'd1;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_FONT  = 2'd1,
		CMD_WIDTH = 2'd2,
		CMD_CHAR  = 2'd3
	} cmd_t;

	// glyph lookup request from the engine
	typedef struct packed {
		logic       re;
		logic [6:0] glyph;
		logic [2:0] row;
	} glyph_rd_t;

	// glyph lookup data back to the engine
	typedef struct packed {
		logic [7:0] font;
		logic [2:0] width;
	} glyph_dat_t;

endpackage

// ----- sv/led_matrix_text_scroller_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_text_scroller_top
// Proportional font text scroller for an LED matrix: load commands fill the
// font, width and message stores, a tick item emits one item per row.
//
//   channel   dir  handshake          payload (low bit up)
//   s_axis    in   s_tvalid/s_tready  tdata: command[1:0] address[11:2] data[19:12]
//   m_axis    out  m_tvalid/m_tready  tdata: row_number[3:0] row_pixels[11:4]
//                                     red_columns[19:12]; tlast: last_row
//   config    in   message_length_we  message_length_wdata[6:0]
//
// Load items go straight into their store and are taken while no tick runs.
// A tick walks each row column by column, then makes a last pass for
// the scroll step; each character change costs a message read followed
// by a glyph read. Reset clears position and direction and sets the red
// column to RED_RESET; stores hold garbage until loaded. A stalled
// m_tready holds the engine at the end of the next row.
// ----------------------------------------------------------------------------
module led_matrix_text_scroller_top import lmts_pkg::*; #(
	parameter int ROWS    = ROWS_DEF,
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int MSG_MAX = MSG_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        message_length_we,
	input  logic [6:0]  message_length_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // command[1:0], address[11:2], data[19:12]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // row_number[3:0], row_pixels[11:4], red_columns[19:12]
	output logic        m_tlast
);

	localparam int PW = (MSG_MAX > 1) ? $clog2(MSG_MAX) : 1;
	localparam int LW = ($clog2(MSG_MAX + 1) > 7) ? $clog2(MSG_MAX + 1) : 7;

	logic [6:0]    msg_len_q;
	logic [LW-1:0] msg_len;
	logic          accept;
	cmd_t          command;
	logic [9:0]    address;
	logic [7:0]    data;
	logic          busy;
	logic          msg_re;
	logic [PW-1:0] msg_addr;
	logic [6:0]    msg_code;
	glyph_rd_t     glyph_rd;
	glyph_dat_t    glyph_dat;

	assign command  = cmd_t'(s_tdata[1:0]);
	assign address  = s_tdata[11:2];
	assign data     = s_tdata[19:12];
	assign s_tready = !busy;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_len_q <= MSG_LEN_RESET;
		end else if (message_length_we) begin
			msg_len_q <= message_length_wdata;
		end
	end

	// clamp the length to 1..MSG_MAX
	always_comb begin
		if (msg_len_q == 7'd0) begin
			msg_len = LW'(1);
		end else if (LW'(msg_len_q) > LW'(MSG_MAX)) begin
			msg_len = LW'(MSG_MAX);
		end else begin
			msg_len = LW'(msg_len_q);
		end
	end

	lmts_ram #(.WIDTH(8), .DEPTH(FONT_DEPTH)) u_font (
		.clk   (clk),
		.we    (accept && command == CMD_FONT && address < 10'(FONT_DEPTH)),
		.waddr (address),
		.wdata (data),
		.re    (glyph_rd.re),
		.raddr ({glyph_rd.glyph, glyph_rd.row}),
		.rdata (glyph_dat.font)
	);

	lmts_ram #(.WIDTH(3), .DEPTH(GLYPHS)) u_width (
		.clk   (clk),
		.we    (accept && command == CMD_WIDTH && address < 10'(GLYPHS)),
		.waddr (address[6:0]),
		.wdata (data[2:0]),
		.re    (glyph_rd.re),
		.raddr (glyph_rd.glyph),
		.rdata (glyph_dat.width)
	);

	lmts_ram #(.WIDTH(7), .DEPTH(MSG_MAX)) u_msg (
		.clk   (clk),
		.we    (accept && command == CMD_CHAR && address < 10'(MSG_MAX)),
		.waddr (address[PW-1:0]),
		.wdata (data[6:0]),
		.re    (msg_re),
		.raddr (msg_addr),
		.rdata (msg_code)
	);

	lmts_engine #(
		.ROWS    (ROWS),
		.COLUMNS (COLUMNS),
		.MSG_MAX (MSG_MAX)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept && command == CMD_TICK),
		.msg_len   (msg_len),
		.busy      (busy),
		.msg_re    (msg_re),
		.msg_addr  (msg_addr),
		.msg_code  (msg_code),
		.glyph_rd  (glyph_rd),
		.glyph_dat (glyph_dat),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

// ----- sv/lmts_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lmts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// hold read data between reads
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/lmts_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmts_engine
// Tick sequencer: walks the columns of each row through the message and
// glyph stores, emits the row items, then advances the scroll position.
// ----------------------------------------------------------------------------
module lmts_engine import lmts_pkg::*; #(
	parameter int ROWS    = ROWS_DEF,
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int MSG_MAX = MSG_MAX_DEF,
	localparam int PW = (MSG_MAX > 1) ? $clog2(MSG_MAX) : 1,
	localparam int LW = ($clog2(MSG_MAX + 1) > 7) ? $clog2(MSG_MAX + 1) : 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [LW-1:0]    msg_len,
	output logic             busy,
	output logic             msg_re,
	output logic [PW-1:0]    msg_addr,
	input  logic [6:0]       msg_code,
	output glyph_rd_t        glyph_rd,
	input  glyph_dat_t       glyph_dat,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [23:0]      m_tdata,
	output logic             m_tlast
);

	localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MSG,
		ST_GLY,
		ST_CALC,
		ST_EMIT
	} state_t;

	state_t        state_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [7:0]    pix_q;
	logic          final_q;
	logic          gvalid_q;
	logic [PW-1:0] wpos_q;
	logic [2:0]    wbit_q;
	logic [PW-1:0] char_pos_q;
	logic [2:0]    bit_pos_q;
	logic          dir_q;
	logic [7:0]    red_q;
	logic          out_valid_q;
	logic [3:0]    out_row_q;
	logic [7:0]    out_pix_q;
	logic [7:0]    out_red_q;
	logic          out_last_q;

	logic [2:0]    width_eff;
	logic [7:0]    bits_eff;
	logic [3:0]    bit_inc;
	logic          char_end;
	logic [LW-1:0] pos_inc;
	logic          wrap;
	logic [PW-1:0] npos;
	logic [2:0]    nbit;
	logic [2:0]    colbit;
	logic          col_last;
	logic          row_last;
	logic          out_free;

	always_comb begin
		width_eff = gvalid_q ? glyph_dat.width : 3'd0;
		bits_eff  = gvalid_q ? glyph_dat.font : 8'd0;
		bit_inc   = {1'b0, wbit_q} + 4'd1;
		char_end  = bit_inc > {1'b0, width_eff};
		pos_inc   = LW'(wpos_q) + LW'(1);
		wrap      = pos_inc >= msg_len;
		npos      = char_end ? (wrap ? '0 : pos_inc[PW-1:0]) : wpos_q;
		nbit      = char_end ? 3'd0 : bit_inc[2:0];
		colbit    = dir_q ? 3'(col_q) : (3'(COLUMNS - 1) - 3'(col_q));
		col_last  = col_q == CW'(COLUMNS - 1);
		row_last  = row_q == RW'(ROWS - 1);
		out_free  = !out_valid_q || m_tready;
	end

	assign busy           = state_q != ST_IDLE;
	assign msg_re         = state_q == ST_MSG;
	assign msg_addr       = wpos_q;
	assign glyph_rd.re    = state_q == ST_GLY;
	assign glyph_rd.glyph = msg_code - FIRST_CODE;
	assign glyph_rd.row   = 3'(row_q);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_red_q, out_pix_q, out_row_q};
	assign m_tlast  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_q       <= '0;
			col_q       <= '0;
			pix_q       <= '0;
			final_q     <= 1'b0;
			gvalid_q    <= 1'b0;
			wpos_q      <= '0;
			wbit_q      <= '0;
			char_pos_q  <= '0;
			bit_pos_q   <= '0;
			dir_q       <= 1'b0;
			red_q       <= RED_RESET;
			out_valid_q <= 1'b0;
		end else begin
			// load a new row item or drop the one just taken
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						row_q   <= '0;
						col_q   <= '0;
						pix_q   <= '0;
						final_q <= 1'b0;
						wpos_q  <= char_pos_q;
						wbit_q  <= bit_pos_q;
						state_q <= ST_MSG;
					end
				end
				ST_MSG: begin
					state_q <= ST_GLY;
				end
				ST_GLY: begin
					gvalid_q <= msg_code >= FIRST_CODE;
					state_q  <= ST_CALC;
				end
				ST_CALC: begin
					if (final_q) begin
						// commit the scroll step, turn the direction on a wrap and rotate the red column
						char_pos_q <= npos;
						bit_pos_q  <= nbit;
						if (char_end && wrap) begin
							dir_q <= ~dir_q;
						end
						red_q   <= (red_q[7] || red_q == 8'd0) ? RED_RESET
							: {red_q[6:0], 1'b0};
						state_q <= ST_IDLE;
					end else begin
						if (bits_eff[wbit_q]) begin
							pix_q[colbit] <= 1'b1;
						end
						wpos_q <= npos;
						wbit_q <= nbit;
						col_q  <= col_q + CW'(1);
						if (col_last) begin
							state_q <= ST_EMIT;
						end else if (char_end) begin
							state_q <= ST_MSG;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_row_q   <= 4'(row_q) + 4'd1;
						out_pix_q   <= pix_q;
						out_red_q   <= ~red_q;
						out_last_q  <= row_last;
						col_q       <= '0;
						pix_q       <= '0;
						wpos_q      <= char_pos_q;
						wbit_q      <= bit_pos_q;
						state_q     <= ST_MSG;
						if (row_last) begin
							final_q <= 1'b1;
						end else begin
							row_q <= row_q + RW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
